[rtl/core/sefp_pkg.sv]
// ----------------------------------------------------------------------------
// sefp_pkg
// shared types and constants of the start/end framed command parser
// ----------------------------------------------------------------------------
package sefp_pkg;

	localparam int MAX_FRAME_BYTES = 32;
	localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);
	localparam int CNT_W           = $clog2(MAX_FRAME_BYTES);
	localparam int JOB_DEPTH       = 2;
	localparam int JOB_PTR_W       = $clog2(JOB_DEPTH);
	localparam int JOB_CNT_W       = $clog2(JOB_DEPTH + 1);
	localparam int RES_DEPTH       = 2;
	localparam int RES_PTR_W       = $clog2(RES_DEPTH);
	localparam int RES_CNT_W       = $clog2(RES_DEPTH + 1);

	// configuration register indexes
	localparam logic [1:0] REG_START_BYTE   = 2'd0;
	localparam logic [1:0] REG_END_BYTE     = 2'd1;
	localparam logic [1:0] REG_RX_MODE_CODE = 2'd2;
	localparam logic [1:0] REG_SEND_CODE    = 2'd3;

	localparam logic [7:0] ENABLE_BYTE = 8'h01;

	typedef enum logic [1:0] {
		KIND_NACK   = 2'd0,
		KIND_RXMODE = 2'd1,
		KIND_SEND   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_LEN,
		ST_CMD,
		ST_DATA,
		ST_END
	} fstate_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_EMIT
	} bstate_t;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] end_byte;
		logic [7:0] rx_mode_code;
		logic [7:0] send_code;
	} cfg_t;

	// one classified frame handed from front to back
	typedef struct packed {
		kind_t            kind;
		logic [7:0]       value;
		logic [CNT_W-1:0] count;
	} job_t;

	typedef struct packed {
		logic             en;
		logic [CNT_W-1:0] addr;
		logic [7:0]       data;
	} buf_wr_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		logic       last;
	} res_t;

endpackage

[rtl/core/stx_etx_frame_parser_core.sv]
// ----------------------------------------------------------------------------
// stx_etx_frame_parser_core
// start/end framed command parser: serial bytes in, ack / nack / data bytes out
// ----------------------------------------------------------------------------
//
//  channel   dir  request moved by         payload
//  input     in   push && !full            rx_byte
//  results   out  pop && !empty            kind, value, last
//  config    in   wr_en                    wr_index, wr_data
//
//  an input byte is taken on push while full is low; a byte that closes a frame
//  becomes a job, a nack or rx-mode result moves from the job queue into the
//  result queue, a send frame is read out of the frame buffer byte by byte
//  through its registered read port (read state, then emit state); a further
//  byte is read only after the last one is pushed, and emit waits on a full result queue
//  full stays high while a send job owns the frame buffer or the job queue
//  is full; empty low means a result waits, held until popped
//  asynchronous reset loads the register defaults; the buffer is not cleared
//
// ----------------------------------------------------------------------------
module stx_etx_frame_parser_core (
	input  logic                clk,
	input  logic                arst_n,
	// byte input queue side
	input  logic                push,
	input  logic [7:0]          rx_byte,
	output logic                full,
	// result queue side
	output logic                empty,
	input  logic                pop,
	output sefp_pkg::kind_t     kind,
	output logic [7:0]          value,
	output logic                last,
	// configuration write port
	input  logic                wr_en,
	input  logic [1:0]          wr_index,
	input  logic [7:0]          wr_data
);
	import sefp_pkg::*;

	cfg_t    cfg_q;
	logic    job_push, job_full, job_pop, job_valid;
	job_t    job_in, job_head;
	buf_wr_t buf_wr;
	logic    send_done;
	res_t    res_head;

	// configuration registers, to be written only while the block is idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte   <= 8'd2;
			cfg_q.end_byte     <= 8'd3;
			cfg_q.rx_mode_code <= 8'd1;
			cfg_q.send_code    <= 8'd2;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_START_BYTE:   cfg_q.start_byte   <= wr_data;
				REG_END_BYTE:     cfg_q.end_byte     <= wr_data;
				REG_RX_MODE_CODE: cfg_q.rx_mode_code <= wr_data;
				REG_SEND_CODE:    cfg_q.send_code    <= wr_data;
				default: ;
			endcase
		end
	end

	// front: frame parsing and classification
	sefp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_push   (push),
		.in_byte   (rx_byte),
		.in_full   (full),
		.cfg       (cfg_q),
		.job_full  (job_full),
		.job_push  (job_push),
		.job       (job_in),
		.buf_wr    (buf_wr),
		.send_done (send_done)
	);

	// decoupling queue of classified frames
	sefp_job_q u_job_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (job_in),
		.q_full   (job_full),
		.pop      (job_pop),
		.q_valid  (job_valid),
		.head     (job_head)
	);

	// back: result generation and buffer streaming
	sefp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job_head),
		.job_pop   (job_pop),
		.buf_wr    (buf_wr),
		.send_done (send_done),
		.res_empty (empty),
		.res_pop   (pop),
		.res_head  (res_head)
	);

	// oldest waiting result
	assign kind  = res_head.kind;
	assign value = res_head.value;
	assign last  = res_head.last;

endmodule

[rtl/core/sefp_front.sv]
// ----------------------------------------------------------------------------
// sefp_front
// byte parser: hunts for the start byte, reads length, command and data,
// writes data bytes to the frame buffer and classifies each frame into a job
// ----------------------------------------------------------------------------
module sefp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_push,
	input  logic [7:0]        in_byte,
	output logic              in_full,
	input  sefp_pkg::cfg_t    cfg,
	input  logic              job_full,
	output logic              job_push,
	output sefp_pkg::job_t    job,
	output sefp_pkg::buf_wr_t buf_wr,
	input  logic              send_done
);
	import sefp_pkg::*;

	fstate_t          state_q, state_d;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       cmd_q;
	logic [CNT_W-1:0] byte_cnt_q;
	logic             first_one_q;
	logic             send_busy_q;
	logic             take;
	logic             len_bad;
	logic             data_done;

	// buffer is owned by a send job until the back side has read it out
	assign in_full   = job_full || send_busy_q;
	assign take      = in_push && !in_full;
	assign len_bad   = (in_byte == 8'd0) || (in_byte > 8'(MAX_FRAME_BYTES));
	assign data_done = (LEN_W'(byte_cnt_q) + LEN_W'(1)) == (len_q - LEN_W'(1));

	// next state
	always_comb begin
		state_d = state_q;
		if (take) begin
			unique case (state_q)
				ST_HUNT: begin
					if (in_byte == cfg.start_byte) state_d = ST_LEN;
				end
				ST_LEN: begin
					state_d = len_bad ? ST_HUNT : ST_CMD;
				end
				ST_CMD: begin
					if (in_byte != 8'd0) state_d = (len_q == LEN_W'(1)) ? ST_END : ST_DATA;
				end
				ST_DATA: begin
					if (data_done) state_d = ST_END;
				end
				ST_END: begin
					state_d = ST_HUNT;
				end
				default: state_d = ST_HUNT;
			endcase
		end
	end

	// outputs
	always_comb begin
		job_push    = 1'b0;
		job.kind    = KIND_NACK;
		job.value   = 8'd0;
		job.count   = '0;
		buf_wr.en   = take && (state_q == ST_DATA);
		buf_wr.addr = byte_cnt_q;
		buf_wr.data = in_byte;
		if (state_q == ST_END) begin
			job_push = take;
			if (in_byte == cfg.end_byte) begin
				priority if (cmd_q == cfg.rx_mode_code) begin
					if (byte_cnt_q != '0) begin
						job.kind  = KIND_RXMODE;
						job.value = {7'd0, first_one_q};
					end
				end else if (cmd_q == cfg.send_code) begin
					if (byte_cnt_q != '0) begin
						job.kind  = KIND_SEND;
						job.count = byte_cnt_q;
					end
				end else begin
					job.kind = KIND_NACK;
				end
			end
		end else if (state_q == ST_LEN) begin
			job_push = take && len_bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_HUNT;
			len_q       <= '0;
			cmd_q       <= 8'd0;
			byte_cnt_q  <= '0;
			first_one_q <= 1'b0;
			send_busy_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				unique case (state_q)
					ST_HUNT: begin
						byte_cnt_q  <= '0;
						cmd_q       <= 8'd0;
						first_one_q <= 1'b0;
					end
					ST_LEN: len_q <= in_byte[LEN_W-1:0];
					ST_CMD: cmd_q <= in_byte;
					ST_DATA: begin
						if (byte_cnt_q == '0) first_one_q <= (in_byte == ENABLE_BYTE);
						byte_cnt_q <= byte_cnt_q + CNT_W'(1);
					end
					ST_END: ;
					default: ;
				endcase
			end
			if (job_push && (job.kind == KIND_SEND)) send_busy_q <= 1'b1;
			else if (send_done) send_busy_q <= 1'b0;
		end
	end

	a_no_wr_while_send: assert property (@(posedge clk) disable iff (!arst_n)
		!(buf_wr.en && send_busy_q))
		else $error("frame buffer written while a send job owns it");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(job_push && job_full))
		else $error("job pushed into a full queue");

endmodule

[rtl/core/sefp_job_q.sv]
// ----------------------------------------------------------------------------
// sefp_job_q
// short queue of classified frames between front and back
// ----------------------------------------------------------------------------
module sefp_job_q (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sefp_pkg::job_t push_job,
	output logic           q_full,
	input  logic           pop,
	output logic           q_valid,
	output sefp_pkg::job_t head
);
	import sefp_pkg::*;

	job_t                 mem_q [JOB_DEPTH];
	logic [JOB_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [JOB_CNT_W-1:0] cnt_q;
	logic                 do_push, do_pop;

	assign q_full  = (cnt_q == JOB_CNT_W'(JOB_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !q_full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_q + JOB_PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_q + JOB_PTR_W'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + JOB_CNT_W'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - JOB_CNT_W'(1);
		end
	end

endmodule

[rtl/core/sefp_back.sv]
// ----------------------------------------------------------------------------
// sefp_back
// job executor: holds the frame buffer, turns jobs into results and streams
// buffered bytes of a send job through a small result queue
// ----------------------------------------------------------------------------
module sefp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  sefp_pkg::job_t    job,
	output logic              job_pop,
	input  sefp_pkg::buf_wr_t buf_wr,
	output logic              send_done,
	output logic              res_empty,
	input  logic              res_pop,
	output sefp_pkg::res_t    res_head
);
	import sefp_pkg::*;

	logic [7:0]           buf_mem [MAX_FRAME_BYTES];
	logic [7:0]           rd_q;
	bstate_t              state_q, state_d;
	logic [CNT_W-1:0]     idx_q, cnt_q;
	logic                 last_byte;
	logic                 rd_en;
	logic                 res_push;
	res_t                 res_in;
	res_t                 res_mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [RES_CNT_W-1:0] res_cnt_q;
	logic                 res_full, do_pop;

	assign res_full  = (res_cnt_q == RES_CNT_W'(RES_DEPTH));
	assign res_empty = (res_cnt_q == '0);
	assign res_head  = res_mem_q[rd_ptr_q];
	assign do_pop    = res_pop && !res_empty;
	assign last_byte = (idx_q == (cnt_q - CNT_W'(1)));

	// frame buffer, registered read
	always_ff @(posedge clk) begin
		if (buf_wr.en) buf_mem[buf_wr.addr] <= buf_wr.data;
		if (rd_en) rd_q <= buf_mem[idx_q];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (job_valid && (job.kind == KIND_SEND)) state_d = B_READ;
			end
			B_READ: state_d = B_EMIT;
			B_EMIT: begin
				if (!res_full) state_d = last_byte ? B_IDLE : B_READ;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		job_pop      = 1'b0;
		res_push     = 1'b0;
		res_in.kind  = job.kind;
		res_in.value = job.value;
		res_in.last  = 1'b1;
		rd_en        = 1'b0;
		send_done    = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					if (job.kind == KIND_SEND) begin
						job_pop = 1'b1;
					end else if (!res_full) begin
						job_pop  = 1'b1;
						res_push = 1'b1;
					end
				end
			end
			B_READ: rd_en = 1'b1;
			B_EMIT: begin
				res_in.kind  = KIND_SEND;
				res_in.value = rd_q;
				res_in.last  = last_byte;
				if (!res_full) begin
					res_push  = 1'b1;
					send_done = last_byte;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (res_push) res_mem_q[wr_ptr_q] <= res_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			idx_q     <= '0;
			cnt_q     <= '0;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == B_IDLE && job_pop && job.kind == KIND_SEND) begin
				cnt_q <= job.count;
				idx_q <= '0;
			end else if (state_q == B_EMIT && res_push && !last_byte) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (res_push)
				wr_ptr_q <= (wr_ptr_q == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr_q + RES_PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_q + RES_PTR_W'(1);
			if (res_push && !do_pop) res_cnt_q <= res_cnt_q + RES_CNT_W'(1);
			else if (do_pop && !res_push) res_cnt_q <= res_cnt_q - RES_CNT_W'(1);
		end
	end

	a_read_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_READ) |=> (state_q == B_EMIT))
		else $error("buffer read not followed by emit");
	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		send_done |-> (res_push && res_in.last && res_in.kind == KIND_SEND))
		else $error("send done without last send result");

endmodule
